### rtl/pfd_pkg.sv
// Shared types and constants for the filtered-derivative PID block.
package pfd_pkg;

	// Register indexes on the configuration port
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 3'd3;

	// Datapath widths
	localparam int unsigned GAIN_W = 16;
	localparam int unsigned ERR_W  = 13;
	localparam int unsigned SUM_W  = 32;
	localparam int unsigned FILT_W = 30;
	localparam int unsigned OPA_W  = 32;
	localparam int unsigned PROD_W = 48;
	localparam int unsigned CMD_W  = 12;

	// Limits in their fixed-point formats
	localparam logic signed [ERR_W-1:0]  ERR_LIMIT   = 13'sd2880;
	localparam logic signed [PROD_W-1:0] INT_MAX_Q12 = 48'sd1044480;
	localparam logic signed [PROD_W-1:0] CMD_MAX_Q20 = 48'sd267386880;
	localparam logic [CMD_W-1:0]         CMD_MAX_Q4  = 12'd4080;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_I,
		ST_MUL_P,
		ST_MUL_KD,
		ST_DIFF,
		ST_MUL_N,
		ST_ADD_D,
		ST_DONE
	} pfd_state_t;

	// Operand pair for the shared multiplier
	typedef enum logic [1:0] {
		MUL_SUM_I,
		MUL_E_P,
		MUL_E_D,
		MUL_DIFF_N
	} pfd_mul_sel_t;

	// Accumulator operations
	typedef enum logic [2:0] {
		ACC_HOLD,
		ACC_LOAD_I,
		ACC_ADD_P,
		ACC_SHIFT,
		ACC_ADD_D
	} pfd_acc_op_t;

	// Control from sequencer to datapath
	typedef struct packed {
		logic         accept;
		logic         mul_en;
		pfd_mul_sel_t mul_sel;
		pfd_acc_op_t  acc_op;
		logic         load_diff;
		logic         finish;
	} pfd_ctrl_t;

endpackage

### rtl/pfd_mul.sv
// Shared signed-by-unsigned multiplier with registered product.
module pfd_mul
	import pfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [OPA_W-1:0]  a,
	input  logic [GAIN_W-1:0]        b,
	output logic signed [PROD_W-1:0] prod_q
);

	logic signed [OPA_W+GAIN_W:0] full;

	// 32 x 17 signed product; result range fits 48 bits
	assign full = a * $signed({1'b0, b});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[PROD_W-1:0];
		end
	end

endmodule

### rtl/pfd_seq.sv
// Step sequencer that schedules the shared multiplier and accumulator.
module pfd_seq
	import pfd_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      out_free,
	output logic      in_ready,
	output pfd_ctrl_t ctrl
);

	pfd_state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and step controls
	always_comb begin
		state_d        = state_q;
		in_ready       = 1'b0;
		ctrl.accept    = 1'b0;
		ctrl.mul_en    = 1'b0;
		ctrl.mul_sel   = MUL_SUM_I;
		ctrl.acc_op    = ACC_HOLD;
		ctrl.load_diff = 1'b0;
		ctrl.finish    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				ctrl.accept = in_valid;
				if (in_valid) begin
					state_d = ST_MUL_I;
				end
			end
			ST_MUL_I: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_SUM_I;
				state_d      = ST_MUL_P;
			end
			ST_MUL_P: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_E_P;
				ctrl.acc_op  = ACC_LOAD_I;
				state_d      = ST_MUL_KD;
			end
			ST_MUL_KD: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_E_D;
				ctrl.acc_op  = ACC_ADD_P;
				state_d      = ST_DIFF;
			end
			ST_DIFF: begin
				ctrl.load_diff = 1'b1;
				ctrl.acc_op    = ACC_SHIFT;
				state_d        = ST_MUL_N;
			end
			ST_MUL_N: begin
				ctrl.mul_en  = 1'b1;
				ctrl.mul_sel = MUL_DIFF_N;
				state_d      = ST_ADD_D;
			end
			ST_ADD_D: begin
				ctrl.acc_op = ACC_ADD_D;
				state_d     = ST_DONE;
			end
			ST_DONE: begin
				// wait for the output slot before committing
				if (out_free) begin
					ctrl.finish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/pid_filtered_derivative.sv
// PID step with filtered derivative: one shared multiplier under a sequencer.
// A request runs through MUL_I, MUL_P, MUL_KD, DIFF, MUL_N, ADD_D and DONE; DONE waits for a free output.
// A new request is taken only in IDLE, once the previous one has passed the eight sequencer states.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) clears gains, error sum, filter state and valids.
module pid_filtered_derivative
	import pfd_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [15:0]       setpoint,
	input  logic signed [15:0]       measured,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [CMD_W-1:0]         command,
	output logic                     saturated
);

	logic [GAIN_W-1:0]        gain_p_q, gain_i_q, gain_d_q, filter_coef_q;
	logic signed [SUM_W-1:0]  error_sum_q;
	logic signed [FILT_W-1:0] filt_q;
	logic signed [FILT_W-1:0] diff_q;
	logic signed [ERR_W-1:0]  e_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_q;
	logic                     out_valid_q;
	logic [CMD_W-1:0]         command_q;
	logic                     saturated_q;

	pfd_ctrl_t                ctrl;
	logic                     out_free;
	logic signed [16:0]       raw_err;
	logic signed [ERR_W-1:0]  err_clamped;
	logic signed [OPA_W-1:0]  mul_a;
	logic [GAIN_W-1:0]        mul_b;
	logic signed [FILT_W-1:0] kde;
	logic signed [SUM_W:0]    sum_next;
	logic signed [SUM_W-1:0]  sum_sat;
	logic [CMD_W-1:0]         cmd_next;
	logic                     sat_next;

	assign out_free = !out_valid_q || out_ready;

	pfd_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			filter_coef_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:      gain_p_q      <= cfg_data;
				REG_GAIN_I:      gain_i_q      <= cfg_data;
				REG_GAIN_D:      gain_d_q      <= cfg_data;
				REG_FILTER_COEF: filter_coef_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Error, clamped to +/-180.0
	assign raw_err = 17'(setpoint) - 17'(measured);

	always_comb begin
		if (raw_err > 17'(ERR_LIMIT)) begin
			err_clamped = ERR_LIMIT;
		end else if (raw_err < -17'(ERR_LIMIT)) begin
			err_clamped = -ERR_LIMIT;
		end else begin
			err_clamped = raw_err[ERR_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			e_q <= err_clamped;
		end
	end

	// Operand selection for the shared multiplier
	always_comb begin
		case (ctrl.mul_sel)
			MUL_SUM_I: begin
				mul_a = error_sum_q;
				mul_b = gain_i_q;
			end
			MUL_E_P: begin
				mul_a = OPA_W'(e_q);
				mul_b = gain_p_q;
			end
			MUL_E_D: begin
				mul_a = OPA_W'(e_q);
				mul_b = gain_d_q;
			end
			MUL_DIFF_N: begin
				mul_a = OPA_W'(diff_q);
				mul_b = filter_coef_q;
			end
			default: begin
				mul_a = error_sum_q;
				mul_b = gain_i_q;
			end
		endcase
	end

	pfd_mul u_mul (
		.clk    (clk),
		.en     (ctrl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// Accumulator: I clamp, + P, scale to Q.20, + D
	always_ff @(posedge clk) begin
		case (ctrl.acc_op)
			ACC_LOAD_I: begin
				if (prod_q < 0) begin
					acc_q <= '0;
				end else if (prod_q > INT_MAX_Q12) begin
					acc_q <= INT_MAX_Q12;
				end else begin
					acc_q <= prod_q;
				end
			end
			ACC_ADD_P:  acc_q <= acc_q + prod_q;
			ACC_SHIFT:  acc_q <= acc_q <<< 8;
			ACC_ADD_D:  acc_q <= acc_q + prod_q;
			default: ;
		endcase
	end

	// Derivative difference against the stored filter value
	assign kde = prod_q[FILT_W-1:0];

	always_ff @(posedge clk) begin
		if (ctrl.load_diff) begin
			diff_q <= kde - filt_q;
		end
	end

	// Error sum with 32-bit saturation
	assign sum_next = (SUM_W+1)'(error_sum_q) + (SUM_W+1)'(e_q);

	always_comb begin
		if (sum_next[SUM_W] != sum_next[SUM_W-1]) begin
			sum_sat = sum_next[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
			                          : {1'b0, {(SUM_W-1){1'b1}}};
		end else begin
			sum_sat = sum_next[SUM_W-1:0];
		end
	end

	// Loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q <= '0;
			filt_q      <= '0;
		end else begin
			if (ctrl.load_diff) begin
				filt_q <= kde;
			end
			if (ctrl.finish) begin
				error_sum_q <= sum_sat;
			end
		end
	end

	// Command saturation to 0..255.0
	always_comb begin
		if (acc_q < 0) begin
			cmd_next = '0;
			sat_next = 1'b1;
		end else if (acc_q > CMD_MAX_Q20) begin
			cmd_next = CMD_MAX_Q4;
			sat_next = 1'b1;
		end else begin
			cmd_next = acc_q[16+CMD_W-1:16];
			sat_next = 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			command_q   <= cmd_next;
			saturated_q <= sat_next;
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;
	assign saturated = saturated_q;

endmodule

### rtl/pfd_checker.sv
// Port-level checks for the PID block, bound to the top level.
module pfd_checker
	import pfd_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [CMD_W-1:0]     command,
	input logic                 saturated
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(command) && $stable(saturated))
		else $error("result changed while stalled");

	// Command stays within 0..255.0
	a_cmd_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> command <= CMD_MAX_Q4)
		else $error("command above limit");

	// A clipped command sits at one of the limits
	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (command == '0 || command == CMD_MAX_Q4))
		else $error("saturated flag without limit value");

	// One request at a time: busy straight after acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("ready straight after a request");

endmodule

bind pid_filtered_derivative pfd_checker u_pfd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.command   (command),
	.saturated (saturated)
);
